@@ design/fri_pkg.sv @@
package fri_pkg;

  localparam int OFFSET_BITS = 40;
  localparam int COUNT_BITS  = 32;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [7:0] HDR_CHAR = 8'h3E;
  localparam logic [7:0] NL_CHAR  = 8'h0A;

  typedef logic [OFFSET_BITS-1:0] pos_t;
  typedef logic [OFFSET_BITS:0]   size_t;
  typedef logic [COUNT_BITS-1:0]  count_t;

  typedef enum logic {
    KIND_RECORD  = 1'b0,
    KIND_SUMMARY = 1'b1
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK             = 2'd0,
    ST_MISSING_HEADER = 2'd1,
    ST_COUNT_MISMATCH = 2'd2,
    ST_COUNT_OVERFLOW = 2'd3
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       final_byte;
  } in_item_t;

  typedef struct packed {
    kind_t   kind;
    pos_t    offset;
    pos_t    prior_size;
    count_t  total_records;
    size_t   largest_record;
    size_t   normalized_size;
    logic    newline_added;
    status_t status;
    logic    last_of_run;
  } out_item_t;

  // One classified byte that produces at least one result.
  typedef struct packed {
    logic   has_rec;
    logic   has_sum;
    pos_t   rec_offset;
    pos_t   prior;
    count_t total;
    pos_t   max_size;
    pos_t   last_start;
    pos_t   size;
    logic   newline;
    logic   halted;
  } entry_t;

endpackage

@@ design/fri_front.sv @@
module fri_front import fri_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     byte_valid,
  output logic     byte_ready,
  input  in_item_t byte_data,
  input  logic     queue_full,
  output logic     push,
  output entry_t   push_entry
);

  logic [7:0] prev_byte;
  pos_t       position;
  pos_t       last_start;
  pos_t       max_size;
  count_t     record_total;
  logic       halted;

  logic       halted_next;
  pos_t       last_start_next;
  pos_t       max_size_next;
  count_t     record_total_next;
  pos_t       position_next;
  pos_t       prior;
  logic       rec_hit;
  logic       pos_zero;
  logic       is_hdr;
  logic       fire;

  assign byte_ready = !queue_full;
  assign fire       = byte_valid && byte_ready;
  assign pos_zero   = (position == '0);
  assign is_hdr     = (byte_data.data_byte == HDR_CHAR);
  assign position_next = position + pos_t'(1);

  always_comb begin
    halted_next       = halted;
    last_start_next   = last_start;
    max_size_next     = max_size;
    record_total_next = record_total;
    prior             = '0;
    rec_hit           = 1'b0;
    if (!halted) begin
      if (pos_zero && !is_hdr) begin
        halted_next = 1'b1;
      end else if (is_hdr && (pos_zero || prev_byte == NL_CHAR)) begin
        if (&record_total) begin
          // The count is saturated; this header is dropped.
          halted_next = 1'b1;
        end else begin
          rec_hit = 1'b1;
          if (record_total != '0) begin
            prior = position - last_start;
            if (prior > max_size) begin
              max_size_next = prior;
            end
          end
          last_start_next   = position;
          record_total_next = record_total + count_t'(1);
        end
      end
    end
  end

  always_comb begin
    push_entry.has_rec    = rec_hit;
    push_entry.has_sum    = byte_data.final_byte;
    push_entry.rec_offset = position;
    push_entry.prior      = prior;
    push_entry.total      = record_total_next;
    push_entry.max_size   = max_size_next;
    push_entry.last_start = last_start_next;
    push_entry.size       = position_next;
    push_entry.newline    = (byte_data.data_byte != NL_CHAR);
    push_entry.halted     = halted_next;
  end

  assign push = fire && (rec_hit || byte_data.final_byte);

  always_ff @(posedge clk) begin
    if (rst) begin
      prev_byte    <= '0;
      position     <= '0;
      last_start   <= '0;
      max_size     <= '0;
      record_total <= '0;
      halted       <= 1'b0;
    end else if (fire) begin
      if (byte_data.final_byte) begin
        prev_byte    <= '0;
        position     <= '0;
        last_start   <= '0;
        max_size     <= '0;
        record_total <= '0;
        halted       <= 1'b0;
      end else begin
        prev_byte    <= byte_data.data_byte;
        position     <= position_next;
        last_start   <= last_start_next;
        max_size     <= max_size_next;
        record_total <= record_total_next;
        halted       <= halted_next;
      end
    end
  end

endmodule

@@ design/fri_queue.sv @@
module fri_queue import fri_pkg::*; (
  input  logic   clk,
  input  logic   rst,
  input  logic   push,
  input  entry_t push_entry,
  output logic   full,
  input  logic   pop,
  output logic   head_valid,
  output entry_t head
);

  localparam int PTR_BITS   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int COUNT_W    = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PTR_BITS-1:0] LAST_SLOT = PTR_BITS'(QUEUE_DEPTH - 1);
  localparam logic [COUNT_W-1:0]  DEPTH_C   = COUNT_W'(QUEUE_DEPTH);

  entry_t               slots [QUEUE_DEPTH];
  logic [PTR_BITS-1:0]  wr_ptr;
  logic [PTR_BITS-1:0]  rd_ptr;
  logic [COUNT_W-1:0]   count;

  assign full       = (count == DEPTH_C);
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == LAST_SLOT) ? '0 : wr_ptr + PTR_BITS'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == LAST_SLOT) ? '0 : rd_ptr + PTR_BITS'(1);
      end
      if (push && !pop) begin
        count <= count + COUNT_W'(1);
      end else if (pop && !push) begin
        count <= count - COUNT_W'(1);
      end
    end
  end

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= DEPTH_C)
    else $error("queue holds more entries than its depth");

  a_pop_nonempty: assert property (@(posedge clk) disable iff (rst)
    pop |-> head_valid)
    else $error("queue popped while empty");

  a_push_not_full: assert property (@(posedge clk) disable iff (rst)
    push |-> !full)
    else $error("queue pushed while full");
`endif

endmodule

@@ design/fri_back.sv @@
module fri_back import fri_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      head_valid,
  input  entry_t    head,
  output logic      pop,
  input  count_t    expected_count,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result_data
);

  logic      rec_done;
  logic      load;
  logic      emit_rec;
  size_t     last_len;
  size_t     largest;
  out_item_t beat_next;

  assign load     = head_valid && (!result_valid || result_ready);
  assign emit_rec = head.has_rec && !rec_done;
  assign pop      = load && !(emit_rec && head.has_sum);

  // Size of the final record, with the appended newline when there is one.
  assign last_len = {1'b0, head.size - head.last_start} + size_t'(head.newline);
  assign largest  = (last_len > {1'b0, head.max_size}) ? last_len : {1'b0, head.max_size};

  always_comb begin
    beat_next.prior_size      = '0;
    beat_next.total_records   = head.total;
    beat_next.largest_record  = {1'b0, head.max_size};
    beat_next.normalized_size = '0;
    beat_next.newline_added   = 1'b0;
    beat_next.status          = ST_OK;
    if (emit_rec) begin
      beat_next.kind        = KIND_RECORD;
      beat_next.offset      = head.rec_offset;
      beat_next.prior_size  = head.prior;
      beat_next.last_of_run = !head.has_sum;
    end else begin
      beat_next.kind        = KIND_SUMMARY;
      beat_next.offset      = head.size;
      beat_next.last_of_run = 1'b1;
      if (head.halted) begin
        beat_next.status = (head.total == '0) ? ST_MISSING_HEADER : ST_COUNT_OVERFLOW;
      end else begin
        beat_next.largest_record  = largest;
        beat_next.normalized_size = {1'b0, head.size} + size_t'(head.newline);
        beat_next.newline_added   = head.newline;
        beat_next.status = (head.total != expected_count) ? ST_COUNT_MISMATCH : ST_OK;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rec_done     <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (load) begin
        rec_done     <= emit_rec && head.has_sum;
        result_valid <= 1'b1;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      result_data <= beat_next;
    end
  end

`ifndef SYNTHESIS
  a_summary_last: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.kind == KIND_SUMMARY) |-> result_data.last_of_run)
    else $error("summary beat without last_of_run");

  a_record_then_summary: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_ready && result_data.kind == KIND_RECORD
     && !result_data.last_of_run)
    |=> (result_valid && result_data.kind == KIND_SUMMARY))
    else $error("record beat not followed by its summary");

  a_record_clean: assert property (@(posedge clk) disable iff (rst)
    (result_valid && result_data.kind == KIND_RECORD)
    |-> (result_data.status == ST_OK && !result_data.newline_added
         && result_data.normalized_size == '0))
    else $error("record beat carries summary fields");
`endif

endmodule

@@ design/fasta_record_indexer_core.sv @@
// Timing: each byte's entry is registered in the queue, and the back end then registers the
// result beat from the queue head; the summary beat of a byte that also starts a record
// follows its record beat. Throughput: one byte per cycle while the queue has room; a byte
// that causes both a record beat and a summary beat holds the back end for both beats, so a
// run of one-byte files slows the input once the two-entry queue has filled.
// Reset (synchronous, active high) empties the pipeline and sets expected_count to 1.
module fasta_record_indexer_core import fri_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      byte_valid,
  output logic      byte_ready,
  input  in_item_t  byte_data,
  output logic      result_valid,
  input  logic      result_ready,
  output out_item_t result_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  count_t    cfg_data
);

  // The single configuration register; writes are always taken. The user must issue them
  // only while the block is idle, which it does not enforce, so no in-flight beat sees a change.
  count_t expected_count;

  logic   push;
  entry_t push_entry;
  logic   queue_full;
  logic   head_valid;
  entry_t head;
  logic   pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      expected_count <= count_t'(1);
    end else if (cfg_valid && cfg_ready) begin
      expected_count <= cfg_data;
    end
  end

  // The front end tracks the stream state one byte per cycle while the queue
  // has room: it spots header characters at the start of a line, measures the
  // record that just ended, keeps the running maximum and count, and flags a
  // missing header or a saturated count. A result byte becomes one queue entry.
  fri_front u_front (
    .clk        (clk),
    .rst        (rst),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .byte_data  (byte_data),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  // The queue decouples the byte side from the result side so that a stalled
  // consumer does not stop the front end until the queue fills.
  fri_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .full       (queue_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head       (head)
  );

  // The back end turns each entry into one or two result beats. The summary
  // math (final record length, normalized size, status) is done here so the
  // front end's per-byte path stays a compare, a subtract and a max.
  fri_back u_back (
    .clk            (clk),
    .rst            (rst),
    .head_valid     (head_valid),
    .head           (head),
    .pop            (pop),
    .expected_count (expected_count),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .result_data    (result_data)
  );

endmodule
